// ===== sv/lpfd_pkg.sv =====
package lpfd_pkg;

    // Stream widths
    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_DATA_W = 104;  // channel 32 + sequence 64 + body 8
    localparam int unsigned KIND_W     = 2;

    // Configuration port
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    // Register indexes (byte address / 4)
    localparam logic REG_MAX_FRAME_LEN = 1'b0;

    // Frame layout
    localparam logic [31:0] HDR_BYTES         = 32'd12;
    localparam logic [31:0] MAX_FRAME_LEN_RST = 32'd16777216;

    // Result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_HEADER    = 2'd0,
        KIND_BODY      = 2'd1,
        KIND_OVERSIZE  = 2'd2,
        KIND_MALFORMED = 2'd3
    } t_kind;

    // Parser phase, one-hot
    typedef enum logic [4:0] {
        PH_LEN  = 5'b00001,
        PH_CHAN = 5'b00010,
        PH_SEQ  = 5'b00100,
        PH_BODY = 5'b01000,
        PH_HALT = 5'b10000
    } t_phase;

    // One result item
    typedef struct packed {
        t_kind       kind;
        logic [31:0] channel_id;
        logic [63:0] sequence_res;
        logic [7:0]  body_byte;
        logic        frame_last;
    } t_result;

endpackage

// ===== sv/length_prefixed_frame_decoder.sv =====
// Length-prefixed frame decoder. Takes one byte per transaction on the s_ side;
// frames are a 4-byte little-endian total length, 4-byte channel id, 8-byte
// sequence number and (length - 12) body bytes. Each byte is parsed in the cycle
// it is accepted, one byte per clock while s_tready is high, and any result is
// registered. A two-entry output stage (register plus skid) lets input
// keep flowing while one result waits; s_tready drops only when both are full.
// A header result (tuser 0) carries channel and sequence, each body byte gives a
// tuser 1 result, tlast marks the last result of a frame. A length above
// max_frame_len (APB address 0) gives tuser 2, below 12 gives tuser 3; after
// either error the block drops all input until reset.
module length_prefixed_frame_decoder
    import lpfd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // APB configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // Byte input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] data_byte
    // Result output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [31:0] channel_id, [95:32] sequence_res,
                                             // [103:96] body_byte
    output logic [KIND_W-1:0]     m_tuser,   // [1:0] kind
    output logic                  m_tlast    // frame_last
);

    logic        w_accept;
    logic        w_can_push;
    logic        w_res_valid;
    logic [31:0] w_max_len;
    t_result     w_res;
    t_result     w_out;

    assign s_tready = w_can_push;
    assign w_accept = s_tvalid & w_can_push;

    lpfd_cfg_regs u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_max_frame_len (w_max_len)
    );

    lpfd_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_byte          (s_tdata),
        .i_max_frame_len (w_max_len),
        .o_res_valid     (w_res_valid),
        .o_res           (w_res)
    );

    lpfd_out_buf u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_res_valid),
        .i_res      (w_res),
        .o_can_push (w_can_push),
        .o_valid    (m_tvalid),
        .i_ready    (m_tready),
        .o_res      (w_out)
    );

    // Pack result fields onto the stream
    assign m_tdata = {w_out.body_byte, w_out.sequence_res, w_out.channel_id};
    assign m_tuser = w_out.kind;
    assign m_tlast = w_out.frame_last;

endmodule

// ===== sv/lpfd_cfg_regs.sv =====
module lpfd_cfg_regs
    import lpfd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [31:0]           o_max_frame_len
);

    logic        w_sel_max_len;
    logic [31:0] r_max_len;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;

    // Register write on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_FRAME_LEN_RST;
        end else if (w_wr && (paddr[2] == REG_MAX_FRAME_LEN)) begin
            r_max_len <= pwdata;
        end
    end

    // Read back; unmapped index reads zero
    always_comb begin
        w_sel_max_len = (paddr[2] == REG_MAX_FRAME_LEN);
        prdata = w_sel_max_len ? r_max_len : '0;
    end

    assign o_max_frame_len = r_max_len;

endmodule

// ===== sv/lpfd_parser.sv =====
module lpfd_parser
    import lpfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_byte,
    input  logic [31:0] i_max_frame_len,
    output logic        o_res_valid,
    output t_result     o_res
);

    t_phase      r_phase,   n_phase;
    logic [2:0]  r_idx,     n_idx;
    logic [31:0] r_length,  n_length;
    logic [31:0] r_channel, n_channel;
    logic [63:0] r_seq,     n_seq;
    logic [31:0] r_remain,  n_remain;
    logic [31:0] w_len_full;
    logic [31:0] w_remain_dec;

    // Length word with the current byte merged in
    always_comb begin
        w_len_full = r_length;
        w_len_full[8*r_idx[1:0] +: 8] = i_byte;
    end

    assign w_remain_dec = r_remain - 32'd1;

    // Next state and result for one byte
    always_comb begin
        n_phase     = r_phase;
        n_idx       = r_idx;
        n_length    = r_length;
        n_channel   = r_channel;
        n_seq       = r_seq;
        n_remain    = r_remain;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_accept) begin
            unique case (r_phase)
                PH_LEN: begin
                    n_length = w_len_full;
                    if (r_idx[1:0] != 2'd3) begin
                        n_idx = r_idx + 3'd1;
                    end else begin
                        n_idx = '0;
                        if (w_len_full > i_max_frame_len) begin
                            n_phase     = PH_HALT;
                            o_res_valid = 1'b1;
                            o_res.kind  = KIND_OVERSIZE;
                        end else if (w_len_full < HDR_BYTES) begin
                            n_phase     = PH_HALT;
                            o_res_valid = 1'b1;
                            o_res.kind  = KIND_MALFORMED;
                        end else begin
                            n_channel = '0;
                            n_phase   = PH_CHAN;
                        end
                    end
                end
                PH_CHAN: begin
                    n_channel[8*r_idx[1:0] +: 8] = i_byte;
                    if (r_idx[1:0] != 2'd3) begin
                        n_idx = r_idx + 3'd1;
                    end else begin
                        n_idx   = '0;
                        n_seq   = '0;
                        n_phase = PH_SEQ;
                    end
                end
                PH_SEQ: begin
                    n_seq[8*r_idx +: 8] = i_byte;
                    if (r_idx != 3'd7) begin
                        n_idx = r_idx + 3'd1;
                    end else begin
                        // Header complete: emit channel and sequence
                        n_idx              = '0;
                        n_remain           = r_length - HDR_BYTES;
                        n_length           = '0;
                        o_res_valid        = 1'b1;
                        o_res.kind         = KIND_HEADER;
                        o_res.channel_id   = r_channel;
                        o_res.sequence_res = n_seq;
                        o_res.frame_last   = (r_length == HDR_BYTES);
                        n_phase            = (r_length == HDR_BYTES) ? PH_LEN : PH_BODY;
                    end
                end
                PH_BODY: begin
                    n_remain           = w_remain_dec;
                    o_res_valid        = 1'b1;
                    o_res.kind         = KIND_BODY;
                    o_res.channel_id   = r_channel;
                    o_res.sequence_res = r_seq;
                    o_res.body_byte    = i_byte;
                    o_res.frame_last   = (w_remain_dec == '0);
                    if (w_remain_dec == '0) begin
                        n_phase  = PH_LEN;
                        n_idx    = '0;
                        n_length = '0;
                    end
                end
                default: begin
                    // Halted: byte is dropped
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_LEN;
            r_idx     <= '0;
            r_length  <= '0;
            r_channel <= '0;
            r_seq     <= '0;
            r_remain  <= '0;
        end else begin
            r_phase   <= n_phase;
            r_idx     <= n_idx;
            r_length  <= n_length;
            r_channel <= n_channel;
            r_seq     <= n_seq;
            r_remain  <= n_remain;
        end
    end

endmodule

// ===== sv/lpfd_out_buf.sv =====
module lpfd_out_buf
    import lpfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_can_push,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_out_valid,  n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out,        n_out;
    t_result r_skid,       n_skid;
    logic    w_pop;

    assign w_pop      = r_out_valid & i_ready;
    assign o_can_push = ~r_skid_valid;
    assign o_valid    = r_out_valid;
    assign o_res      = r_out;

    // Output register plus one skid entry
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (w_pop) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || w_pop) begin
                n_out       = i_res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = i_res;
                n_skid_valid = 1'b1;
            end
        end else if (w_pop) begin
            n_out_valid = 1'b0;
        end
    end

    // Control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

endmodule
